// ----- sv/mieu_pkg.sv -----
// shared types and constants for the integer execute unit
package mieu_pkg;

	localparam int unsigned RegCount = 32;
	localparam int unsigned RegIdxW  = $clog2(RegCount);

	// input commands
	localparam logic [1:0] CMD_EXEC  = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_ENTRY = 2'd2;
	localparam logic [1:0] CMD_WREG  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FAULT  = 2'd1;
	localparam logic [1:0] ST_UNIMPL = 2'd2;

	// config register indexes
	localparam logic CFG_CODE_BASE  = 1'b0;
	localparam logic CFG_DATA_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DIVFIX,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic exec;
		logic div_step;
		logic div_fix;
		logic out_valid_set;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_last;
	} stat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] syscall_number;
		logic        syscall;
		logic [31:0] mem_write_data;
		logic [31:0] mem_address;
		logic        mem_byte;
		logic        mem_write;
		logic        mem_read;
		logic [31:0] pc;
	} result_t;

endpackage

// ----- sv/mieu_ctrl.sv -----
// controller state machine for the integer execute unit
module mieu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_beat,
	input  logic            out_free,
	input  mieu_pkg::stat_t stat,
	output mieu_pkg::cmd_t  cmd,
	output logic            busy
);

	mieu_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mieu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mieu_pkg::ST_IDLE: begin
				if (in_beat) state_d = mieu_pkg::ST_EXEC;
			end
			mieu_pkg::ST_EXEC: begin
				state_d = stat.need_div ? mieu_pkg::ST_DIV : mieu_pkg::ST_OUT;
			end
			mieu_pkg::ST_DIV: begin
				if (stat.div_last) state_d = mieu_pkg::ST_DIVFIX;
			end
			mieu_pkg::ST_DIVFIX: state_d = mieu_pkg::ST_OUT;
			mieu_pkg::ST_OUT: begin
				if (out_free) state_d = mieu_pkg::ST_IDLE;
			end
			default: state_d = mieu_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			mieu_pkg::ST_IDLE: begin
				busy        = 1'b0;
				cmd.load_in = in_beat;
			end
			mieu_pkg::ST_EXEC:   cmd.exec = 1'b1;
			mieu_pkg::ST_DIV:    cmd.div_step = 1'b1;
			mieu_pkg::ST_DIVFIX: cmd.div_fix = 1'b1;
			mieu_pkg::ST_OUT:    cmd.out_valid_set = out_free;
			default: busy = 1'b1;
		endcase
	end

endmodule

// ----- sv/mieu_dp.sv -----
// datapath: register file, alu, multiplier, serial divider, pc logic
module mieu_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  mieu_pkg::cmd_t    cmd,
	output mieu_pkg::stat_t   stat,
	input  logic [1:0]        in_command,
	input  logic [31:0]       in_word,
	input  logic [4:0]        in_reg_index,
	input  logic              cfg_we,
	input  logic              cfg_sel,
	input  logic [31:0]       cfg_data,
	output mieu_pkg::result_t res
);

	// accepted beat
	logic [1:0]  command_q;
	logic [31:0] word_q;
	logic [4:0]  idx_q;

	logic [31:0] code_base_q, data_limit_q;
	logic [31:0] regs_q [mieu_pkg::RegCount];
	logic [31:0] pc_q, npc_q, hi_q, lo_q;
	logic [4:0]  pl_dest_q;
	logic        pl_byte_q, pl_valid_q;

	// divider state
	logic [31:0] dq_q, dr_q, dd_q;
	logic [31:0] da_q, db_q;
	logic        dna_q, dnb_q, dspecial_q;
	logic [4:0]  dcnt_q;

	mieu_pkg::result_t res_q;

	// decode
	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sh;
	logic [15:0] imm;
	logic [31:0] a, b, simm, addr, link;
	assign op   = word_q[31:26];
	assign rs   = word_q[25:21];
	assign rt   = word_q[20:16];
	assign rd   = word_q[15:11];
	assign sh   = word_q[10:6];
	assign fn   = word_q[5:0];
	assign imm  = word_q[15:0];
	assign a    = (rs == 5'd0) ? 32'd0 : regs_q[rs];
	assign b    = (rt == 5'd0) ? 32'd0 : regs_q[rt];
	assign simm = {{16{imm[15]}}, imm};
	assign addr = a + simm;
	assign link = npc_q + 32'd4;

	logic [63:0] prod_u;
	logic signed [65:0] prod_s;
	assign prod_u = {32'd0, a} * {32'd0, b};
	assign prod_s = $signed({a[31], a}) * $signed({b[31], b});

	// execute decision
	logic        wr_en;
	logic [4:0]  wr_idx;
	logic [31:0] wr_val;
	logic [31:0] pc_n, npc_n, hi_n, lo_n;
	logic        hilo_en, div_start, div_sgn;
	mieu_pkg::result_t r;
	logic        fault, taken, neg;

	always_comb begin
		wr_en     = 1'b0;
		wr_idx    = rd;
		wr_val    = '0;
		pc_n      = npc_q;
		npc_n     = npc_q + 32'd4;
		hi_n      = hi_q;
		lo_n      = lo_q;
		hilo_en   = 1'b0;
		div_start = 1'b0;
		div_sgn   = 1'b0;
		r         = '0;
		fault     = pc_q >= data_limit_q;
		neg       = a[31];
		taken     = 1'b0;
		if (fault) begin
			pc_n     = pc_q;
			npc_n    = npc_q;
			r.status = mieu_pkg::ST_FAULT;
		end else if (op == 6'h00) begin
			wr_en = 1'b1;
			case (fn)
				6'h00: wr_val = b << sh;
				6'h02: wr_val = b >> sh;
				6'h03: wr_val = 32'($signed(b) >>> sh);
				6'h04: wr_val = b << a[4:0];
				6'h06: wr_val = b >> a[4:0];
				6'h08: begin
					wr_en = 1'b0;
					npc_n = code_base_q + a;
				end
				6'h09: begin
					wr_val = link;
					npc_n  = code_base_q + a;
				end
				6'h0c: begin
					wr_en            = 1'b0;
					r.syscall        = 1'b1;
					r.syscall_number = regs_q[2];
				end
				6'h10: wr_val = hi_q;
				6'h12: wr_val = lo_q;
				6'h18: begin
					wr_en   = 1'b0;
					hilo_en = 1'b1;
					lo_n    = prod_s[31:0];
					hi_n    = prod_s[63:32];
				end
				6'h19: begin
					wr_en   = 1'b0;
					hilo_en = 1'b1;
					lo_n    = prod_u[31:0];
					hi_n    = prod_u[63:32];
				end
				6'h1a: begin
					wr_en     = 1'b0;
					div_start = 1'b1;
					div_sgn   = 1'b1;
				end
				6'h1b: begin
					wr_en     = 1'b0;
					div_start = 1'b1;
				end
				6'h20, 6'h21: wr_val = a + b;
				6'h22, 6'h23: wr_val = a - b;
				6'h24: wr_val = a & b;
				6'h25: wr_val = a | b;
				6'h26: wr_val = a ^ b;
				6'h27: wr_val = ~(a | b);
				6'h2a: wr_val = {31'd0, $signed(a) < $signed(b)};
				6'h2b: wr_val = {31'd0, a < b};
				default: begin
					wr_en    = 1'b0;
					r.status = mieu_pkg::ST_UNIMPL;
				end
			endcase
		end else begin
			wr_idx = rt;
			case (op)
				6'h01: begin
					case (rt)
						5'd0:  taken = neg;
						5'd1:  taken = !neg;
						5'd16: begin
							taken  = neg;
							wr_en  = 1'b1;
							wr_idx = 5'd31;
							wr_val = link;
						end
						5'd17: begin
							taken  = !neg;
							wr_en  = 1'b1;
							wr_idx = 5'd31;
							wr_val = link;
						end
						default: r.status = mieu_pkg::ST_UNIMPL;
					endcase
				end
				6'h02, 6'h03: begin
					wr_en  = op[0];
					wr_idx = 5'd31;
					wr_val = link;
					npc_n  = code_base_q + {npc_q[31:28], word_q[25:0], 2'b00};
				end
				6'h04: taken = a == b;
				6'h05: taken = a != b;
				6'h06: taken = neg || a == 32'd0;
				6'h07: taken = !neg && a != 32'd0;
				6'h08, 6'h09: begin
					wr_en  = 1'b1;
					wr_val = addr;
				end
				6'h0a: begin
					wr_en  = 1'b1;
					wr_val = {31'd0, $signed(a) < $signed(simm)};
				end
				6'h0b: begin
					wr_en  = 1'b1;
					wr_val = {31'd0, a < simm};
				end
				6'h0c: begin
					wr_en  = 1'b1;
					wr_val = a & {16'd0, imm};
				end
				6'h0d: begin
					wr_en  = 1'b1;
					wr_val = a | {16'd0, imm};
				end
				6'h0e: begin
					wr_en  = 1'b1;
					wr_val = a ^ {16'd0, imm};
				end
				6'h0f: begin
					wr_en  = 1'b1;
					wr_val = {imm, 16'd0};
				end
				6'h20, 6'h23: begin
					r.mem_read    = 1'b1;
					r.mem_byte    = !op[0];
					r.mem_address = addr;
				end
				6'h28, 6'h2b: begin
					r.mem_write      = 1'b1;
					r.mem_byte       = !op[0];
					r.mem_address    = addr;
					r.mem_write_data = op[0] ? b : {24'd0, b[7:0]};
				end
				default: r.status = mieu_pkg::ST_UNIMPL;
			endcase
			// branches use the offset form of the next pc
			if (op == 6'h01 || (op >= 6'h04 && op <= 6'h07)) begin
				if (taken) npc_n = npc_q + {simm[29:0], 2'b00};
			end
		end
		r.pc = pc_n;
	end

	// result of non-execute commands carries only the pc
	logic [31:0] pc_other;
	assign pc_other = (command_q == mieu_pkg::CMD_ENTRY) ? word_q : pc_q;

	// serial restoring divider over magnitudes, one bit a cycle
	logic [32:0] dtrial;
	logic [31:0] drem_sh;
	assign drem_sh = {dr_q[30:0], dd_q[31]};
	assign dtrial  = {dr_q, dd_q[31]} - {1'b0, db_q};
	assign stat.need_div = div_start && command_q == mieu_pkg::CMD_EXEC;
	assign stat.div_last = dcnt_q == 5'd31;

	// load returned data
	logic [31:0] ld_val;
	assign ld_val = pl_byte_q ? {{24{word_q[7]}}, word_q[7:0]} : word_q;

	logic [31:0] qfix, rfix;
	assign qfix = (dna_q != dnb_q) ? 32'd0 - dq_q : dq_q;
	assign rfix = dna_q ? 32'd0 - dr_q : dr_q;

	// config and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_base_q  <= '0;
			data_limit_q <= '1;
			pc_q         <= '0;
			npc_q        <= '0;
			hi_q         <= '0;
			lo_q         <= '0;
			pl_dest_q    <= '0;
			pl_byte_q    <= 1'b0;
			pl_valid_q   <= 1'b0;
			dcnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_sel == mieu_pkg::CFG_CODE_BASE) code_base_q <= cfg_data;
				else data_limit_q <= cfg_data;
			end
			if (cmd.exec) begin
				case (command_q)
					mieu_pkg::CMD_EXEC: begin
						pc_q  <= pc_n;
						npc_q <= npc_n;
						if (hilo_en) begin
							hi_q <= hi_n;
							lo_q <= lo_n;
						end
						if (!fault && (op == 6'h20 || op == 6'h23)) begin
							pl_dest_q  <= rt;
							pl_byte_q  <= !op[0];
							pl_valid_q <= 1'b1;
						end
					end
					mieu_pkg::CMD_LOAD: pl_valid_q <= 1'b0;
					mieu_pkg::CMD_ENTRY: begin
						pc_q  <= word_q;
						npc_q <= word_q + 32'd4;
					end
					default: ;
				endcase
				dcnt_q <= '0;
			end
			if (cmd.div_step) dcnt_q <= dcnt_q + 5'd1;
			if (cmd.div_fix) begin
				if (db_q == 32'd0 && !dspecial_q) begin
					lo_q <= '1;
					hi_q <= da_q;
				end else if (dspecial_q) begin
					lo_q <= 32'h8000_0000;
					hi_q <= '0;
				end else begin
					lo_q <= qfix;
					hi_q <= rfix;
				end
			end
		end
	end

	// payload registers: input beat, divider, result
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			command_q <= in_command;
			word_q    <= in_word;
			idx_q     <= in_reg_index;
		end
		if (cmd.exec) begin
			res_q <= (command_q == mieu_pkg::CMD_EXEC) ? r
				: mieu_pkg::result_t'({102'd0, pc_other});
			da_q       <= a;
			dna_q      <= div_sgn & a[31];
			dnb_q      <= div_sgn & b[31];
			dspecial_q <= div_sgn && a == 32'h8000_0000 && b == '1;
			dd_q       <= (div_sgn & a[31]) ? 32'd0 - a : a;
			db_q       <= (div_sgn & b[31]) ? 32'd0 - b : b;
			dr_q       <= '0;
			dq_q       <= '0;
		end
		if (cmd.div_step) begin
			dd_q <= {dd_q[30:0], 1'b0};
			if (!dtrial[32]) begin
				dr_q <= dtrial[31:0];
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				dr_q <= drem_sh;
				dq_q <= {dq_q[30:0], 1'b0};
			end
		end
	end

	// register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mieu_pkg::RegCount; i++) regs_q[i] <= '0;
		end else if (cmd.exec) begin
			if (command_q == mieu_pkg::CMD_EXEC && !fault && wr_en && wr_idx != 5'd0)
				regs_q[wr_idx] <= wr_val;
			else if (command_q == mieu_pkg::CMD_LOAD && pl_valid_q && pl_dest_q != 5'd0)
				regs_q[pl_dest_q] <= ld_val;
			else if (command_q == mieu_pkg::CMD_WREG && idx_q != 5'd0)
				regs_q[idx_q] <= word_q;
		end
	end

	assign res = res_q;

endmodule

// ----- sv/mips_integer_execute_unit.sv -----
// top level of the integer execute unit
// Each beat takes one command and yields one result beat. The result passes
// through the execute and output states before it is valid; div and divu also
// pass through the one-bit-a-cycle divider and its sign fixup. One command is in
// flight at a time; the output register holds a result until taken and the next
// beat is accepted only once that result has left.
module mips_integer_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // command[1:0], word[33:2], reg_index[38:34]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [135:0] m_tdata,  // pc, mem_read, mem_write, mem_byte, mem_address,
	                               // mem_write_data, syscall, syscall_number, status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	mieu_pkg::cmd_t    cmd;
	mieu_pkg::stat_t   stat;
	mieu_pkg::result_t res;
	logic busy, m_valid_q, out_free, in_beat;

	assign s_tready  = !busy && !m_valid_q;
	assign in_beat   = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	// output valid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_valid_set) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// result packing, holds while valid
	logic [135:0] m_data_q;
	always_ff @(posedge clk) begin
		if (cmd.out_valid_set) begin
			m_data_q <= {2'd0, res};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	mieu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_beat  (in_beat),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	mieu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_command   (s_tdata[1:0]),
		.in_word      (s_tdata[33:2]),
		.in_reg_index (s_tdata[38:34]),
		.cfg_we       (cfg_valid),
		.cfg_sel      (cfg_index),
		.cfg_data     (cfg_data),
		.res          (res)
	);

endmodule

// ----- sv/mieu_checker.sv -----
// port-level checker for the integer execute unit, bound to the top level
module mieu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [135:0] m_tdata
);

	// a held result keeps its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// no input while a result waits
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("accepted beat while result pending");

	// result never follows accept immediately
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid)
		else $error("result too early");

	// status code never 3
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[133:132] != 2'd3)
		else $error("bad status");

endmodule

bind mips_integer_execute_unit mieu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ----- sim/mips_integer_execute_unit_test.sv -----
// self-checking testbench for the integer execute unit
`timescale 1ns / 1ps

module mips_integer_execute_unit_test;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_REGIMM  = 6'h01;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0a;
	localparam logic [5:0] OP_SLTIU   = 6'h0b;
	localparam logic [5:0] OP_ANDI    = 6'h0c;
	localparam logic [5:0] OP_ORI     = 6'h0d;
	localparam logic [5:0] OP_XORI    = 6'h0e;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SW      = 6'h2b;
	// special function codes
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_SLLV    = 6'h04;
	localparam logic [5:0] FN_SRLV    = 6'h06;
	localparam logic [5:0] FN_SRAV    = 6'h07;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0c;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_DIV     = 6'h1a;
	localparam logic [5:0] FN_DIVU    = 6'h1b;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2a;
	localparam logic [5:0] FN_SLTU    = 6'h2b;
	// regimm selectors
	localparam logic [4:0] RI_BLTZ    = 5'd0;
	localparam logic [4:0] RI_BGEZ    = 5'd1;
	localparam logic [4:0] RI_BLTZAL  = 5'd16;
	localparam logic [4:0] RI_BGEZAL  = 5'd17;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic         cfg_index = 1'b0;
	logic [31:0]  cfg_data = '0;

	mips_integer_execute_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the architectural state
	logic [31:0] gpr [mieu_pkg::RegCount];
	logic [31:0] pc_q, npc_q, hi_q, lo_q, code_base_q, data_limit_q;
	logic [4:0]  load_dst_q;
	logic        load_byte_q, load_pend_q;

	logic [39:0]       cmd_queue [$];
	mieu_pkg::result_t result_queue [$];
	int          errors = 0;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	logic        s_taken = 1'b1;

	initial forever #1 clk = ~clk;

	function automatic logic [31:0] sext16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic void set_reg(logic [4:0] i, logic [31:0] v);
		if (i != 5'd0)
			gpr[i] = v;
	endfunction

	function automatic void take_branch(logic taken, logic [15:0] imm);
		pc_q = npc_q;
		npc_q = npc_q + (taken ? (sext16(imm) << 2) : 32'd4);
	endfunction

	function automatic void do_divide(logic [31:0] a, logic [31:0] b, logic sgn);
		if (b == 32'd0) begin
			lo_q = 32'hffffffff;
			hi_q = a;
		end else if (!sgn) begin
			lo_q = a / b;
			hi_q = a % b;
		end else if (a == 32'h80000000 && b == 32'hffffffff) begin
			lo_q = 32'h80000000;
			hi_q = 32'd0;
		end else begin
			lo_q = $signed(a) / $signed(b);
			hi_q = $signed(a) % $signed(b);
		end
	endfunction

	// execute one instruction word on the shadow state, returns status
	function automatic logic [1:0] run_instr(logic [31:0] w, inout mieu_pkg::result_t r);
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd, sh;
		logic [15:0] imm;
		logic [31:0] a, b, addr;
		logic [63:0] p;
		logic        done;
		op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
		sh = w[10:6]; fn = w[5:0]; imm = w[15:0];
		a = gpr[rs]; b = gpr[rt];
		addr = a + sext16(imm);
		done = 1'b0;
		if (op == OP_SPECIAL) begin
			case (fn)
				FN_SLL:  set_reg(rd, b << sh);
				FN_SRL:  set_reg(rd, b >> sh);
				FN_SRA:  set_reg(rd, $signed(b) >>> sh);
				FN_SLLV: set_reg(rd, b << a[4:0]);
				FN_SRLV: set_reg(rd, b >> a[4:0]);
				FN_JR, FN_JALR: begin
					if (fn == FN_JALR)
						set_reg(rd, npc_q + 32'd4);
					pc_q = npc_q;
					npc_q = code_base_q + a;
					done = 1'b1;
				end
				FN_SYSCALL: begin
					r.syscall = 1'b1;
					r.syscall_number = gpr[2];
				end
				FN_MFHI: set_reg(rd, hi_q);
				FN_MFLO: set_reg(rd, lo_q);
				FN_MULT: begin
					p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
					{hi_q, lo_q} = p;
				end
				FN_MULTU: begin
					p = {32'd0, a} * {32'd0, b};
					{hi_q, lo_q} = p;
				end
				FN_DIV:  do_divide(a, b, 1'b1);
				FN_DIVU: do_divide(a, b, 1'b0);
				FN_ADD, FN_ADDU: set_reg(rd, a + b);
				FN_SUB, FN_SUBU: set_reg(rd, a - b);
				FN_AND:  set_reg(rd, a & b);
				FN_OR:   set_reg(rd, a | b);
				FN_XOR:  set_reg(rd, a ^ b);
				FN_NOR:  set_reg(rd, ~(a | b));
				FN_SLT:  set_reg(rd, {31'd0, $signed(a) < $signed(b)});
				FN_SLTU: set_reg(rd, {31'd0, a < b});
				default: begin
					pc_q = npc_q; npc_q = npc_q + 32'd4;
					return mieu_pkg::ST_UNIMPL;
				end
			endcase
			if (!done) begin
				pc_q = npc_q; npc_q = npc_q + 32'd4;
			end
			return mieu_pkg::ST_OK;
		end
		case (op)
			OP_REGIMM: begin
				case (rt)
					RI_BLTZ: take_branch(a[31], imm);
					RI_BGEZ: take_branch(!a[31], imm);
					RI_BLTZAL, RI_BGEZAL: begin
						set_reg(5'd31, npc_q + 32'd4);
						take_branch(rt == RI_BLTZAL ? a[31] : !a[31], imm);
					end
					default: begin
						pc_q = npc_q; npc_q = npc_q + 32'd4;
						return mieu_pkg::ST_UNIMPL;
					end
				endcase
				return mieu_pkg::ST_OK;
			end
			OP_J, OP_JAL: begin
				if (op == OP_JAL)
					set_reg(5'd31, npc_q + 32'd4);
				pc_q = npc_q;
				npc_q = code_base_q + {pc_q[31:28], w[25:0], 2'b00};
				return mieu_pkg::ST_OK;
			end
			OP_BEQ:  begin take_branch(a == b, imm); return mieu_pkg::ST_OK; end
			OP_BNE:  begin take_branch(a != b, imm); return mieu_pkg::ST_OK; end
			OP_BLEZ: begin take_branch(a[31] || a == 32'd0, imm); return mieu_pkg::ST_OK; end
			OP_BGTZ: begin take_branch(!a[31] && a != 32'd0, imm); return mieu_pkg::ST_OK; end
			OP_ADDI, OP_ADDIU: set_reg(rt, addr);
			OP_SLTI:  set_reg(rt, {31'd0, $signed(a) < $signed(sext16(imm))});
			OP_SLTIU: set_reg(rt, {31'd0, a < sext16(imm)});
			OP_ANDI:  set_reg(rt, a & {16'd0, imm});
			OP_ORI:   set_reg(rt, a | {16'd0, imm});
			OP_XORI:  set_reg(rt, a ^ {16'd0, imm});
			OP_LUI:   set_reg(rt, {imm, 16'd0});
			OP_LB, OP_LW: begin
				load_dst_q = rt;
				load_byte_q = (op == OP_LB);
				load_pend_q = 1'b1;
				r.mem_read = 1'b1;
				r.mem_byte = load_byte_q;
				r.mem_address = addr;
			end
			OP_SB, OP_SW: begin
				r.mem_write = 1'b1;
				r.mem_byte = (op == OP_SB);
				r.mem_address = addr;
				r.mem_write_data = (op == OP_SB) ? {24'd0, b[7:0]} : b;
			end
			default: begin
				pc_q = npc_q; npc_q = npc_q + 32'd4;
				return mieu_pkg::ST_UNIMPL;
			end
		endcase
		pc_q = npc_q; npc_q = npc_q + 32'd4;
		return mieu_pkg::ST_OK;
	endfunction

	// expected result of one command beat
	function automatic mieu_pkg::result_t predict_result(logic [39:0] beat);
		mieu_pkg::result_t r;
		logic [1:0]  cmd;
		logic [31:0] w;
		cmd = beat[1:0];
		w = beat[33:2];
		r = '0;
		case (cmd)
			mieu_pkg::CMD_EXEC: begin
				if (pc_q >= data_limit_q)
					r.status = mieu_pkg::ST_FAULT;
				else
					r.status = run_instr(w, r);
			end
			mieu_pkg::CMD_LOAD: begin
				if (load_pend_q) begin
					set_reg(load_dst_q, load_byte_q ? {{24{w[7]}}, w[7:0]} : w);
					load_pend_q = 1'b0;
				end
			end
			mieu_pkg::CMD_ENTRY: begin
				pc_q = w;
				npc_q = w + 32'd4;
			end
			default: set_reg(beat[38:34], w);
		endcase
		r.pc = pc_q;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report(what, got, want);
	endtask

	// reset state of the shadow model
	initial begin
		for (int i = 0; i < mieu_pkg::RegCount; i++)
			gpr[i] = '0;
		pc_q = '0; npc_q = '0; hi_q = '0; lo_q = '0;
		code_base_q = '0; data_limit_q = 32'hffffffff;
		load_dst_q = '0; load_byte_q = 1'b0; load_pend_q = 1'b0;
	end

	// input beat accept and prediction; cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n && s_tvalid && s_tready) begin
			result_queue.push_back(predict_result(s_tdata));
			void'(cmd_queue.pop_front());
			s_taken = 1'b1;
		end
	end

	// command driver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_taken)) begin
			if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= cmd_queue[0];
				s_taken = 1'b0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side ready, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		mieu_pkg::result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = mieu_pkg::result_t'(m_tdata[133:0]);
			if (result_queue.size() == 0) begin
				report("unexpected beat pc", got.pc, 32'd0);
			end else begin
				want = result_queue.pop_front();
				check_field("pc", got.pc, want.pc);
				check_field("mem_read", got.mem_read, want.mem_read);
				check_field("mem_write", got.mem_write, want.mem_write);
				check_field("mem_byte", got.mem_byte, want.mem_byte);
				check_field("mem_address", got.mem_address, want.mem_address);
				check_field("mem_write_data", got.mem_write_data, want.mem_write_data);
				check_field("syscall", got.syscall, want.syscall);
				check_field("syscall_number", got.syscall_number, want.syscall_number);
				check_field("status", got.status, want.status);
			end
		end
	end

	task automatic send(logic [1:0] cmd, logic [31:0] w, logic [4:0] idx);
		cmd_queue.push_back({1'b0, idx, w, cmd});
	endtask

	task automatic cfg_write(logic idx, logic [31:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		if (idx == mieu_pkg::CFG_CODE_BASE)
			code_base_q = v;
		else
			data_limit_q = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		while (cmd_queue.size() != 0 || result_queue.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
	endfunction

	function automatic logic [15:0] pick_imm();
		case ($urandom_range(3))
			0: return 16'($urandom_range(15));
			1: return 16'hffff - 16'($urandom_range(15));
			default: return 16'($urandom);
		endcase
	endfunction

	// one random instruction, mostly well formed
	function automatic logic [31:0] gen_instr();
		logic [5:0] ops [20] = '{OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ,
			OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI,
			OP_XORI, OP_LUI, OP_LB, OP_LW, OP_SB, OP_SW, OP_LH};
		logic [5:0] fns [26] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
			FN_JR, FN_JALR, FN_SYSCALL, FN_MFHI, FN_MFLO, FN_MULT, FN_MULTU,
			FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
			FN_XOR, FN_NOR, FN_SLT, FN_SLTU, 6'h3f};
		logic [4:0] ri [5] = '{RI_BLTZ, RI_BGEZ, RI_BLTZAL, RI_BGEZAL, 5'd2};
		logic [5:0] op;
		int k;
		k = $urandom_range(99);
		if (k < 6)
			return $urandom;
		if (k < 50)
			return {OP_SPECIAL, pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
				fns[$urandom_range(25)]};
		op = ops[$urandom_range(19)];
		if (op == OP_REGIMM)
			return {op, pick_reg(), ri[$urandom_range(4)], pick_imm()};
		if (op == OP_J || op == OP_JAL)
			return {op, 26'($urandom)};
		return {op, pick_reg(), pick_reg(), pick_imm()};
	endfunction

	// random program stretch with load returns, preloads and re-entries
	task automatic gen_program(int count, logic [31:0] entry_span);
		logic [31:0] w;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(19))
				0: send(mieu_pkg::CMD_ENTRY, $urandom_range(entry_span) & 32'hfffffffc,
					5'($urandom));
				1, 2: send(mieu_pkg::CMD_WREG, ($urandom_range(1) ? $urandom
					: $urandom_range(9) - 32'd4), 5'($urandom));
				3: send(mieu_pkg::CMD_LOAD, $urandom, 5'($urandom));
				default: begin
					w = gen_instr();
					send(mieu_pkg::CMD_EXEC, w, 5'($urandom));
					if ((w[31:26] == OP_LB || w[31:26] == OP_LW) && $urandom_range(3) != 0) begin
						send(mieu_pkg::CMD_LOAD, $urandom, 5'($urandom));
						n++;
					end
				end
			endcase
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(posedge clk);

		// directed checks at the reset settings
		send(mieu_pkg::CMD_WREG, 32'hffffffff, 5'd1);
		send(mieu_pkg::CMD_WREG, 32'h80000000, 5'd2);
		send(mieu_pkg::CMD_WREG, 32'd0, 5'd31);
		send(mieu_pkg::CMD_WREG, 32'h12345678, 5'd0);
		send(mieu_pkg::CMD_ENTRY, 32'h00001000, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_ADD}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_SPECIAL, 5'd1, 5'd0, 5'd4, 5'd0, FN_NOR}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_SPECIAL, 5'd2, 5'd1, 5'd5, 5'd0, FN_SLTU}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, FN_MULT}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_SPECIAL, 5'd0, 5'd0, 5'd6, 5'd0, FN_MFHI}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_SPECIAL, 5'd2, 5'd0, 5'd0, 5'd0, FN_DIV}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_SPECIAL, 5'd0, 5'd0, 5'd7, 5'd0, FN_MFLO}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_SPECIAL, 5'd2, 5'd1, 5'd0, 5'd0, FN_DIV}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_SPECIAL, 5'd0, 5'd0, 5'd7, 5'd0, FN_MFHI}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_LB, 5'd2, 5'd8, 16'h8000}, 5'd0);
		send(mieu_pkg::CMD_LOAD, 32'h000000f0, 5'd0);
		send(mieu_pkg::CMD_LOAD, 32'h55555555, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_LW, 5'd1, 5'd0, 16'h7fff}, 5'd0);
		send(mieu_pkg::CMD_LOAD, 32'hdeadbeef, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_SB, 5'd1, 5'd8, 16'h0001}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_REGIMM, 5'd2, RI_BLTZAL, 16'hfffe}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_SPECIAL, 5'd31, 5'd0, 5'd9, 5'd0, FN_JALR}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_JAL, 26'h3ffffff}, 5'd0);
		send(mieu_pkg::CMD_EXEC, {OP_LH, 5'd1, 5'd3, 16'h0000}, 5'd0);
		drain();

		// jump offset at its top, every execute faulting
		cfg_write(mieu_pkg::CFG_CODE_BASE, 32'hffffffff);
		cfg_write(mieu_pkg::CFG_DATA_LIMIT, 32'd0);
		gen_program(40, 32'hffffffff);
		drain();

		// no idling
		cfg_write(mieu_pkg::CFG_CODE_BASE, 32'd0);
		cfg_write(mieu_pkg::CFG_DATA_LIMIT, 32'hffffffff);
		gen_program(250, 32'hffffffff);
		drain();

		// sender idle, small data region limit so faults occur
		send_idle_pct = 64;
		cfg_write(mieu_pkg::CFG_CODE_BASE, $urandom_range(255) << 2);
		cfg_write(mieu_pkg::CFG_DATA_LIMIT, 32'h00002000);
		send(mieu_pkg::CMD_ENTRY, 32'd0, 5'd0);
		gen_program(250, 32'h00002400);
		drain();

		// receiver stalling
		send_idle_pct = 0;
		recv_stall_pct = 64;
		cfg_write(mieu_pkg::CFG_CODE_BASE, $urandom);
		cfg_write(mieu_pkg::CFG_DATA_LIMIT, 32'hfffffff0);
		gen_program(250, 32'hffffffff);
		drain();

		// both idling
		send_idle_pct = 32;
		recv_stall_pct = 32;
		cfg_write(mieu_pkg::CFG_CODE_BASE, 32'h00400000);
		cfg_write(mieu_pkg::CFG_DATA_LIMIT, $urandom);
		gen_program(230, 32'hffffffff);
		drain();

		// long result hold-off while commands keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		gen_program(130, 32'hffffffff);
		repeat (5) @(posedge clk);
		hold_req++;
		drain();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- mips_integer_execute_unit.f -----
sv/mieu_pkg.sv
sv/mieu_ctrl.sv
sv/mieu_dp.sv
sv/mips_integer_execute_unit.sv
sv/mieu_checker.sv
sim/mips_integer_execute_unit_test.sv
